// ===== hw/rtl/wpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared codes, character constants and types of the wildcard matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int DEF_MAX_ELEMS = 32;
    localparam int COL_W         = 8;   // column index width, covers 256 elements

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PATTERN = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_ANY   = 2'd1;
    localparam logic [1:0] KIND_STAR  = 2'd2;
    localparam logic [1:0] KIND_CLASS = 2'd3;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_OPEN   = 3'd2;
    localparam logic [2:0] MODE_BODY   = 3'd3;
    localparam logic [2:0] MODE_DASH   = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    localparam logic [8:0] PREV_NONE = 9'h100;

    // class table write: rows lo..hi of one column get val
    typedef struct packed {
        logic             en;
        logic [7:0]       lo;
        logic [7:0]       hi;
        logic [COL_W-1:0] col;
        logic             val;
    } wpm_wr_req_t;

endpackage

// ===== hw/rtl/wpm_class_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_class_mem
// Class membership table, one row per byte value, one column per element.
// Bit-write port with a row sweep engine; registered read with forwarding.
// ----------------------------------------------------------------------------
module wpm_class_mem #(
    parameter int MAX_ELEMS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wpm_pkg::wpm_wr_req_t wr_req,
    output logic                 busy,
    input  logic                 rd_en,
    input  logic [7:0]           rd_row,
    output logic [MAX_ELEMS-1:0] rd_data
);
    import wpm_pkg::*;

    localparam int CW = $clog2(MAX_ELEMS);

    logic [MAX_ELEMS-1:0] mem [256];
    logic [MAX_ELEMS-1:0] rd_q;

    logic             busy_reg;
    logic [7:0]       row_reg;
    logic [7:0]       end_reg;
    logic [COL_W-1:0] col_reg;
    logic             val_reg;

    // same-row write seen at read time, applied on the read data
    logic             fwd_reg;
    logic [CW-1:0]    fwd_col_reg;
    logic             fwd_val_reg;

    logic             we;
    logic [7:0]       wrow;
    logic [CW-1:0]    wcol;
    logic             wval;

    always_comb begin
        we   = busy_reg || wr_req.en;
        wrow = busy_reg ? row_reg : wr_req.lo;
        wcol = busy_reg ? col_reg[CW-1:0] : wr_req.col[CW-1:0];
        wval = busy_reg ? val_reg : wr_req.val;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wrow][wcol] <= wval;
        end
        if (rd_en) begin
            rd_q        <= mem[rd_row];
            fwd_reg     <= we && wrow == rd_row;
            fwd_col_reg <= wcol;
            fwd_val_reg <= wval;
        end
    end

    always_comb begin
        rd_data = rd_q;
        if (fwd_reg) begin
            rd_data[fwd_col_reg] = fwd_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            if (row_reg == end_reg) begin
                busy_reg <= 1'b0;
            end
            row_reg <= row_reg + 8'd1;
        end else if (wr_req.en && wr_req.lo != wr_req.hi) begin
            busy_reg <= 1'b1;
            row_reg  <= wr_req.lo + 8'd1;
            end_reg  <= wr_req.hi;
            col_reg  <= wr_req.col;
            val_reg  <= wr_req.val;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hw/rtl/wpm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_core
// Pattern compiler and NFA step: element registers, active set, match latch.
// ----------------------------------------------------------------------------
module wpm_core #(
    parameter int MAX_ELEMS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 strobe,
    input  logic [1:0]           action,
    input  logic [7:0]           data_byte,
    input  logic [MAX_ELEMS-1:0] row_data,
    output wpm_pkg::wpm_wr_req_t wr_req,
    output logic                 res_matched,
    output logic                 res_overflow
);
    import wpm_pkg::*;

    localparam int N    = MAX_ELEMS;
    localparam int CW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);

    logic [1:0]    kind_reg [N];
    logic [7:0]    lit_reg  [N];
    logic          neg_reg  [N];

    logic [N:0]      act_reg,   act_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [2:0]      mode_reg,  mode_next;
    logic [8:0]      prev_reg,  prev_next;
    logic            tl_reg,    tl_next;
    logic            latch_reg, latch_next;

    logic            alloc_en;
    logic [1:0]      alloc_kind;
    logic            neg_en;
    logic            neg_val;
    logic [CW-1:0]   neg_idx;
    logic [CNTW-1:0] cnt_m1;
    logic            cnt_full;

    logic [N-1:0] valid_v, star_v, acc_v, hit_v, x_v;
    logic [N:0]   sum_v, cur_v;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid_v[i] = CNTW'(i) < count_reg;
            star_v[i]  = valid_v[i] && kind_reg[i] == KIND_STAR;
            case (kind_reg[i])
                KIND_LIT:   acc_v[i] = lit_reg[i] == data_byte;
                KIND_CLASS: acc_v[i] = row_data[i] ^ neg_reg[i];
                default:    acc_v[i] = 1'b1;
            endcase
        end
        // star closure as a carry chain
        x_v   = act_reg[N-1:0] & star_v;
        sum_v = {1'b0, star_v} + {1'b0, x_v};
        cur_v = act_reg | (sum_v ^ {1'b0, star_v} ^ {1'b0, x_v});
        hit_v = cur_v[N-1:0] & valid_v & acc_v;
    end

    always_comb begin
        act_next   = act_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        tl_next    = tl_reg;
        latch_next = latch_reg;
        alloc_en   = 1'b0;
        alloc_kind = KIND_LIT;
        neg_en     = 1'b0;
        neg_val    = 1'b0;
        cnt_m1     = count_reg - 1'b1;
        cnt_full   = count_reg == CNTW'(N);
        neg_idx    = cnt_m1[CW-1:0];
        wr_req     = '0;
        wr_req.col = COL_W'(cnt_m1[CW-1:0]);
        wr_req.val = 1'b1;

        res_matched  = !tl_reg && mode_reg != MODE_ESCAPE && (latch_reg || cur_v[count_reg]);
        res_overflow = tl_reg;

        if (strobe) begin
            case (action)
                ACT_CLEAR: begin
                    act_next   = (N + 1)'(1);
                    count_next = '0;
                    mode_next  = MODE_NORMAL;
                    prev_next  = PREV_NONE;
                    tl_next    = 1'b0;
                    latch_next = 1'b0;
                end
                ACT_PATTERN: begin
                    if (!tl_reg) begin
                        case (mode_reg)
                            MODE_ESCAPE: begin
                                mode_next = MODE_NORMAL;
                                alloc_en  = 1'b1;
                            end
                            MODE_DASH: begin
                                if (prev_reg <= {1'b0, data_byte}) begin
                                    wr_req.en = 1'b1;
                                    wr_req.lo = prev_reg[7:0];
                                    wr_req.hi = data_byte;
                                end
                                prev_next = {1'b0, data_byte};
                                mode_next = MODE_BODY;
                            end
                            MODE_OPEN, MODE_BODY: begin
                                if (mode_reg == MODE_OPEN && data_byte == CH_CARET) begin
                                    neg_en    = 1'b1;
                                    neg_val   = 1'b1;
                                    mode_next = MODE_BODY;
                                end else if (data_byte == CH_RBRACK) begin
                                    mode_next = MODE_NORMAL;
                                end else if (data_byte == CH_DASH) begin
                                    mode_next = MODE_DASH;
                                end else begin
                                    wr_req.en = 1'b1;
                                    wr_req.lo = data_byte;
                                    wr_req.hi = data_byte;
                                    prev_next = {1'b0, data_byte};
                                    mode_next = MODE_BODY;
                                end
                            end
                            default: begin
                                if (data_byte == CH_BSLASH) begin
                                    mode_next = MODE_ESCAPE;
                                end else begin
                                    alloc_en = 1'b1;
                                    if (data_byte == CH_QUEST) begin
                                        alloc_kind = KIND_ANY;
                                    end else if (data_byte == CH_STAR) begin
                                        alloc_kind = KIND_STAR;
                                    end else if (data_byte == CH_LBRACK) begin
                                        alloc_kind = KIND_CLASS;
                                    end
                                end
                            end
                        endcase
                        if (alloc_en) begin
                            if (cnt_full) begin
                                tl_next  = 1'b1;
                                alloc_en = 1'b0;
                            end else begin
                                count_next = count_reg + 1'b1;
                                if (alloc_kind == KIND_CLASS) begin
                                    // fresh column: clear all 256 rows
                                    wr_req.en  = 1'b1;
                                    wr_req.lo  = 8'd0;
                                    wr_req.hi  = 8'hFF;
                                    wr_req.col = COL_W'(count_reg[CW-1:0]);
                                    wr_req.val = 1'b0;
                                    neg_en     = 1'b1;
                                    neg_idx    = count_reg[CW-1:0];
                                    prev_next  = PREV_NONE;
                                    mode_next  = MODE_OPEN;
                                end
                            end
                        end
                    end
                end
                ACT_TEXT: begin
                    if (data_byte == CH_SLASH && cur_v[count_reg]) begin
                        latch_next = 1'b1;
                    end
                    act_next = {1'b0, hit_v & star_v} | {hit_v & ~star_v, 1'b0};
                end
                default: begin
                    act_next   = (N + 1)'(1);
                    latch_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (alloc_en) begin
            kind_reg[count_reg[CW-1:0]] <= alloc_kind;
            lit_reg[count_reg[CW-1:0]]  <= data_byte;
        end
        if (neg_en) begin
            neg_reg[neg_idx] <= neg_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= (N + 1)'(1);
            count_reg <= '0;
            mode_reg  <= MODE_NORMAL;
            prev_reg  <= PREV_NONE;
            tl_reg    <= 1'b0;
            latch_reg <= 1'b0;
        end else begin
            act_reg   <= act_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            tl_reg    <= tl_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== hw/rtl/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Glob matcher: compiles pattern bytes into elements, runs text as an NFA.
// ----------------------------------------------------------------------------
// Input channel (s_): one beat carries s_action and s_data_byte. Clear,
// pattern byte, text byte or end of text. Only end of text yields a result
// beat on the m_ channel: m_matched and m_pattern_overflow.
// A beat is read from the class table on acceptance and processed from the
// stage register; the result beat is registered on m_ once the end-of-text
// beat is processed.
// Throughput is one beat per cycle for text bytes, plain pattern bytes and
// single class members while no result stall holds an end of text. A class
// opening '[' holds s_ready low while its table column is cleared, one row
// per cycle; a class range lo-hi holds it low while rows lo to hi are
// written. Both are set by the single write port of the 256-row class table.
// Reset (or a clear beat) empties the pattern and rearms the automaton; the
// class table needs no clearing pass. A stalled result register keeps
// accepting beats until a second end of text reaches the processing stage.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
    parameter int MAX_ELEMS = wpm_pkg::DEF_MAX_ELEMS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic       m_pattern_overflow
);
    import wpm_pkg::*;

    logic       st_valid_reg;
    logic [1:0] st_action_reg;
    logic [7:0] st_byte_reg;
    logic       m_valid_reg;
    logic       m_matched_reg;
    logic       m_ovf_reg;

    logic                 adv;
    logic                 s_fire;
    logic                 mem_busy;
    logic                 multi;
    logic [MAX_ELEMS-1:0] row_data;
    logic                 res_matched;
    logic                 res_overflow;
    wpm_wr_req_t          wr_req;

    assign adv    = st_valid_reg &&
                    !(st_action_reg == ACT_END && m_valid_reg && !m_ready);
    assign multi  = wr_req.en && wr_req.lo != wr_req.hi;
    assign s_ready = !mem_busy && !(st_valid_reg && (!adv || multi));
    assign s_fire = s_valid && s_ready;

    wpm_class_mem #(
        .MAX_ELEMS(MAX_ELEMS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (wr_req),
        .busy    (mem_busy),
        .rd_en   (s_fire),
        .rd_row  (s_data_byte),
        .rd_data (row_data)
    );

    wpm_core #(
        .MAX_ELEMS(MAX_ELEMS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .strobe       (adv),
        .action       (st_action_reg),
        .data_byte    (st_byte_reg),
        .row_data     (row_data),
        .wr_req       (wr_req),
        .res_matched  (res_matched),
        .res_overflow (res_overflow)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                st_valid_reg <= 1'b1;
            end else if (adv) begin
                st_valid_reg <= 1'b0;
            end
            if (adv && st_action_reg == ACT_END) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_action_reg <= s_action;
            st_byte_reg   <= s_data_byte;
        end
        if (adv && st_action_reg == ACT_END) begin
            m_matched_reg <= res_matched;
            m_ovf_reg     <= res_overflow;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_ovf_reg;

    // sweep runs only with the processing stage drained
    a_busy_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> !st_valid_reg)
        else $error("class sweep overlaps a beat in the processing stage");

    a_fire_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> st_valid_reg)
        else $error("accepted beat lost before processing");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && st_action_reg == ACT_END) |=> m_valid_reg)
        else $error("end of text produced no result beat");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !(adv && st_action_reg == ACT_END)) |=> !m_valid_reg)
        else $error("result beat without end of text");

endmodule
